// ----- rtl/mts_pkg.sv -----
// Shared types and constants for the markup token scanner.
// Used by mts_front, mts_queue, markup_token_scanner and mts_checker.
package mts_pkg;

  typedef enum logic [4:0] {
    K_EOF        = 5'd0,
    K_ERROR      = 5'd1,
    K_DOCUMENT   = 5'd2,
    K_HEAD       = 5'd3,
    K_TITLE      = 5'd4,
    K_CONTAINER  = 5'd5,
    K_BODY       = 5'd6,
    K_HEADING1   = 5'd7,
    K_HEADING2   = 5'd8,
    K_HEADING3   = 5'd9,
    K_HEADING4   = 5'd10,
    K_HEADING5   = 5'd11,
    K_HEADING6   = 5'd12,
    K_PARAGRAPH  = 5'd13,
    K_TEXT       = 5'd14,
    K_RAW        = 5'd15,
    K_CSS        = 5'd16,
    K_LPAREN     = 5'd17,
    K_RPAREN     = 5'd18,
    K_BANG       = 5'd19,
    K_IDENTIFIER = 5'd20
  } kind_t;

  typedef enum logic [2:0] {
    M_LINESTART = 3'd0,
    M_IDLE      = 3'd1,
    M_WORD      = 3'd2,
    M_COMMENT   = 3'd3,
    M_SLASH     = 3'd4,
    M_TEXT      = 3'd5,
    M_RAW       = 3'd6
  } mode_t;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BANG   = 8'h21;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [7:0]  tabs;
    logic [15:0] len;
    logic [23:0] start;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     t0;
    token_t     t1;
  } front_out_t;

endpackage

// ----- rtl/mts_front.sv -----
// Front end of the markup token scanner: byte classification, scan state
// and token building, up to two tokens per byte. Depends on mts_pkg.
module mts_front #(
  parameter int KEYWORD_CHARS = 9,
  parameter int OFFSET_BITS   = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          char_code,
  input  logic                end_flag,
  output mts_pkg::front_out_t fout
);

  localparam int KIW = $clog2(KEYWORD_CHARS);
  localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;

  mts_pkg::mode_t    mode, mode_next;
  logic [7:0]        wchars [KEYWORD_CHARS];
  logic [15:0]       wlen, wlen_next;
  logic [15:0]       line, line_next;
  logic [15:0]       col, col_next;
  logic [7:0]        tabs, tabs_next;
  logic [OFFSET_BITS-1:0] bpos, bpos_next;
  logic [OFFSET_BITS-1:0] tbegin, tbegin_next;
  logic              wc_we;
  logic [KIW-1:0]    wc_idx;
  logic [71:0]       wv;
  mts_pkg::kind_t    wkind;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [15:0] inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [23:0] ofs24(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+23:0] x;
    x = {24'd0, v};
    return x[23:0];
  endfunction

  function automatic mts_pkg::token_t mk(input mts_pkg::kind_t k, input logic [15:0] ln,
                                         input logic [15:0] cl, input logic [7:0] tb,
                                         input logic [15:0] len, input logic [23:0] st);
    mts_pkg::token_t t;
    t.kind  = k;
    t.line  = ln;
    t.col   = (cl >= len) ? cl - len : 16'd0;
    t.tabs  = tb;
    t.len   = len;
    t.start = st;
    t.last  = 1'b0;
    return t;
  endfunction

  // Keyword classification on the stored word, first char in the top byte.
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      wv[71-8*i -: 8] = wchars[i];
    end
    wkind = mts_pkg::K_IDENTIFIER;
    if (wlen == 16'd1 && wv[71-:8] == "p") begin
      wkind = mts_pkg::K_PARAGRAPH;
    end else begin
      case (wv[71-:8])
        "b": if (wlen == 16'd4 && wv[71-:32] == "body") wkind = mts_pkg::K_BODY;
        "c": begin
          if ((wlen == 16'd3 && wv[71-:24] == "con") ||
              (wlen == 16'd9 && wv[71-:72] == "container")) wkind = mts_pkg::K_CONTAINER;
          else if (wlen == 16'd7 && wv[71-:56] == "content") wkind = mts_pkg::K_BODY;
          else if (wlen == 16'd3 && wv[71-:24] == "css") wkind = mts_pkg::K_CSS;
        end
        "d": begin
          if (wlen == 16'd8 && wv[71-:64] == "document") wkind = mts_pkg::K_DOCUMENT;
          else if (wlen == 16'd3 && wv[71-:24] == "div") wkind = mts_pkg::K_CONTAINER;
          else if (wlen == 16'd4 && wv[71-:32] == "data") wkind = mts_pkg::K_HEAD;
        end
        "h": begin
          if (wlen >= 16'd2 && wv[63-:8] >= "1" && wv[63-:8] <= "6")
            wkind = mts_pkg::kind_t'(5'd7 + 5'(wv[63-:8] - "1"));
          else if (wlen == 16'd4 && wv[71-:32] == "head") wkind = mts_pkg::K_HEAD;
        end
        "t": if (wlen == 16'd5 && wv[71-:40] == "title") wkind = mts_pkg::K_TITLE;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic do_idle;
    logic [1:0] n;
    mts_pkg::token_t tk;
    mode_next   = mode;
    wlen_next   = wlen;
    line_next   = line;
    col_next    = col;
    tabs_next   = tabs;
    tbegin_next = tbegin;
    bpos_next   = (bpos < OFS_MAX) ? bpos + 1'b1 : bpos;
    wc_we       = 1'b0;
    wc_idx      = '0;
    do_idle     = 1'b0;
    n           = 2'd0;
    tk          = '0;
    fout        = '0;
    if (end_flag) begin
      if (mode == mts_pkg::M_WORD || mode == mts_pkg::M_SLASH ||
          mode == mts_pkg::M_TEXT || mode == mts_pkg::M_RAW) begin
        if (mode == mts_pkg::M_WORD) tk = mk(wkind, line, col, tabs, wlen, ofs24(tbegin));
        else if (mode == mts_pkg::M_SLASH)
          tk = mk(mts_pkg::K_ERROR, line, col, tabs, 16'd1, ofs24(tbegin));
        else tk = mk(mts_pkg::K_ERROR, line, col, tabs, wlen, ofs24(tbegin));
        fout.t0 = tk;
        n = 2'd1;
      end
      tk = mk(mts_pkg::K_EOF, line, col, tabs, 16'd0, ofs24(bpos));
      if (n == 2'd0) fout.t0 = tk;
      else fout.t1 = tk;
      n = n + 2'd1;
      // return to the reset state
      mode_next   = mts_pkg::M_LINESTART;
      wlen_next   = '0;
      line_next   = 16'd1;
      col_next    = '0;
      tabs_next   = '0;
      bpos_next   = '0;
      tbegin_next = '0;
    end else begin
      unique case (mode)
        mts_pkg::M_LINESTART: begin
          if (char_code == mts_pkg::CH_CR || char_code == mts_pkg::CH_TAB) begin
            tabs_next = (tabs == 8'hFF) ? tabs : tabs + 8'd1;
            col_next  = inc16(col);
          end else do_idle = 1'b1;
        end
        mts_pkg::M_WORD: begin
          if (is_alnum(char_code)) begin
            wc_we     = (wlen < 16'(KEYWORD_CHARS));
            wc_idx    = wlen[KIW-1:0];
            wlen_next = inc16(wlen);
            col_next  = inc16(col);
          end else begin
            fout.t0 = mk(wkind, line, col, tabs, wlen, ofs24(tbegin));
            n = 2'd1;
            do_idle = 1'b1;
          end
        end
        mts_pkg::M_SLASH: begin
          if (char_code == mts_pkg::CH_SLASH) begin
            mode_next = mts_pkg::M_COMMENT;
            col_next  = inc16(col);
          end else begin
            fout.t0 = mk(mts_pkg::K_ERROR, line, col, tabs, 16'd1, ofs24(tbegin));
            n = 2'd1;
            do_idle = 1'b1;
          end
        end
        mts_pkg::M_COMMENT: begin
          if (char_code == mts_pkg::CH_NL) do_idle = 1'b1;
          else col_next = inc16(col);
        end
        mts_pkg::M_TEXT, mts_pkg::M_RAW: begin
          if (char_code == ((mode == mts_pkg::M_TEXT) ? mts_pkg::CH_QUOTE
                                                       : mts_pkg::CH_BTICK)) begin
            fout.t0 = mk((mode == mts_pkg::M_TEXT) ? mts_pkg::K_TEXT : mts_pkg::K_RAW,
                         line, col, tabs, wlen, ofs24(tbegin));
            n = 2'd1;
            col_next  = inc16(col);
            mode_next = mts_pkg::M_IDLE;
          end else if (char_code == mts_pkg::CH_NL) begin
            line_next = inc16(line);
            col_next  = 16'd1;
            wlen_next = inc16(wlen);
          end else begin
            col_next  = inc16(col);
            wlen_next = inc16(wlen);
          end
        end
        default: do_idle = 1'b1;
      endcase
      if (do_idle) begin
        mode_next = mts_pkg::M_IDLE;
        if (char_code == mts_pkg::CH_SPACE || char_code == mts_pkg::CH_CR ||
            char_code == mts_pkg::CH_TAB) begin
          col_next = inc16(col);
        end else if (char_code == mts_pkg::CH_NL) begin
          line_next = inc16(line);
          col_next  = '0;
          tabs_next = '0;
          mode_next = mts_pkg::M_LINESTART;
        end else begin
          tbegin_next = bpos;
          col_next    = inc16(col);
          if (char_code == mts_pkg::CH_QUOTE || char_code == mts_pkg::CH_BTICK) begin
            wlen_next = 16'd1;
            mode_next = (char_code == mts_pkg::CH_QUOTE) ? mts_pkg::M_TEXT : mts_pkg::M_RAW;
          end else if (char_code == mts_pkg::CH_SLASH) begin
            mode_next = mts_pkg::M_SLASH;
          end else if (is_alnum(char_code)) begin
            wc_we     = 1'b1;
            wc_idx    = '0;
            wlen_next = 16'd1;
            mode_next = mts_pkg::M_WORD;
          end else begin
            if (char_code == mts_pkg::CH_LPAREN)
              tk = mk(mts_pkg::K_LPAREN, line, col_next, tabs, 16'd1, ofs24(bpos));
            else if (char_code == mts_pkg::CH_RPAREN)
              tk = mk(mts_pkg::K_RPAREN, line, col_next, tabs, 16'd1, ofs24(bpos));
            else if (char_code == mts_pkg::CH_BANG)
              tk = mk(mts_pkg::K_BANG, line, col_next, tabs, 16'd1, ofs24(bpos));
            else tk = mk(mts_pkg::K_ERROR, line, col_next, tabs, 16'd1, ofs24(bpos));
            if (n == 2'd0) fout.t0 = tk;
            else fout.t1 = tk;
            n = n + 2'd1;
          end
        end
      end
    end
    // mark the last word of this byte
    if (n == 2'd1) fout.t0.last = 1'b1;
    if (n == 2'd2) fout.t1.last = 1'b1;
    fout.count = take ? n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= mts_pkg::M_LINESTART;
    end else if (take) begin
      mode <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wlen   <= '0;
      line   <= 16'd1;
      col    <= '0;
      tabs   <= '0;
      bpos   <= '0;
      tbegin <= '0;
    end else if (take) begin
      wlen   <= wlen_next;
      line   <= line_next;
      col    <= col_next;
      tabs   <= tabs_next;
      bpos   <= bpos_next;
      tbegin <= tbegin_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !end_flag && wc_we) begin
      wchars[wc_idx] <= char_code;
    end
  end

endmodule

// ----- rtl/mts_queue.sv -----
// Token queue between scanner front and result port: two writes, one read.
// Depends on mts_pkg.
module mts_queue (
  input  logic                clk,
  input  logic                rst,
  input  mts_pkg::front_out_t fin,
  input  logic                rd,
  output logic                full,
  output logic                empty,
  output mts_pkg::token_t     head
);

  mts_pkg::token_t mem [mts_pkg::QUEUE_DEPTH];
  logic [mts_pkg::QUEUE_AW-1:0] wp, rp;
  logic [mts_pkg::QUEUE_AW:0]   cnt;
  logic                         rd_ok;

  assign empty = (cnt == '0);
  // hold back the producer unless two words fit
  assign full  = (cnt > (mts_pkg::QUEUE_AW+1)'(mts_pkg::QUEUE_DEPTH - 2));
  assign rd_ok = rd && !empty;
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    if (fin.count != 2'd0) mem[wp] <= fin.t0;
    if (fin.count == 2'd2) mem[wp + 1'b1] <= fin.t1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + mts_pkg::QUEUE_AW'(fin.count);
      rp  <= rp + mts_pkg::QUEUE_AW'(rd_ok);
      cnt <= cnt + (mts_pkg::QUEUE_AW+1)'(fin.count) - (mts_pkg::QUEUE_AW+1)'(rd_ok);
    end
  end

endmodule

// ----- rtl/markup_token_scanner.sv -----
// Top level of the markup token scanner: front scanner plus token queue.
// Depends on mts_pkg, mts_front and mts_queue.
//
// Usage:
//   Input channel: drive char_code/end_flag and raise push; a byte is taken
//   on a clock edge where push is high and full is low. end_flag marks the
//   end of the source; char_code is then ignored.
//   Result channel: while empty is low the oldest token word sits on the
//   result ports; pop on a clock edge with empty low takes it.
//   Each byte yields zero, one or two words; last_flag marks the final word
//   of a byte, and the end mark always yields an EOF word with last_flag.
// Timing:
//   One byte per cycle while the receiver keeps up and bytes yield no more
//   than one word on average. The front classifies the byte and updates
//   the scan state in the cycle it is taken; its words are registered into a
//   four-entry queue whose head drives the ports. Keyword matching runs on the
//   stored word chars when the word ends, in the same cycle.
//   full rises when fewer than two queue slots are free, so a stalled
//   receiver backs up the input once three or four words are queued.
// Reset: rst (synchronous) empties the queue and returns the scanner to the
//   start of a line, line 1, column 0. After the end mark the scanner
//   returns to that same state on its own.
module markup_token_scanner #(
  parameter int KEYWORD_CHARS = 9,
  parameter int OFFSET_BITS   = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_code,
  input  logic        end_flag,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  token_kind,
  output logic [15:0] line_number,
  output logic [15:0] column,
  output logic [7:0]  indent_tabs,
  output logic [15:0] token_length,
  output logic [23:0] start_offset,
  output logic        last_flag
);

  mts_pkg::front_out_t fout;
  mts_pkg::token_t     head;
  logic                take;

  // accept a byte only when the queue has room for two words
  assign take = push && !full;

  mts_front #(
    .KEYWORD_CHARS(KEYWORD_CHARS),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .char_code(char_code),
    .end_flag (end_flag),
    .fout     (fout)
  );

  mts_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .fin  (fout),
    .rd   (pop),
    .full (full),
    .empty(empty),
    .head (head)
  );

  assign token_kind   = head.kind;
  assign line_number  = head.line;
  assign column       = head.col;
  assign indent_tabs  = head.tabs;
  assign token_length = head.len;
  assign start_offset = head.start;
  assign last_flag    = head.last;

endmodule

// ----- rtl/mts_checker.sv -----
// Port checker for the markup token scanner, bound to the top level.
// Depends on mts_pkg and markup_token_scanner.
module mts_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [4:0]  token_kind,
  input logic [15:0] line_number,
  input logic [15:0] token_length,
  input logic        last_flag
);

  // reset drains the queue
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("queue not empty after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> token_kind <= 5'(mts_pkg::K_IDENTIFIER))
    else $error("token kind out of range");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty |-> line_number != 16'd0)
    else $error("line number zero");

  // an EOF word is the final word of its byte and has no length
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && token_kind == 5'(mts_pkg::K_EOF)) |-> (last_flag && token_length == 16'd0))
    else $error("bad EOF word");

  // a waiting word holds until it is taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(token_kind)))
    else $error("result word changed while waiting");

endmodule

bind markup_token_scanner mts_checker u_mts_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .token_kind  (token_kind),
  .line_number (line_number),
  .token_length(token_length),
  .last_flag   (last_flag)
);

// ----- verif/tb_markup_token_scanner.sv -----
// Self-checking testbench for markup_token_scanner: a byte driver, a token monitor
// and a scanner model that predicts every token word. Depends on mts_pkg and the RTL.
`timescale 1ns / 1ps

module tb_markup_token_scanner;

  localparam int WORD_MAX = 9;
  localparam logic [23:0] POS_MAX = 24'hFFFFFF;
  localparam int ITEMS = 1250;

  typedef struct {
    logic [7:0] c;
    logic       e;
    logic       hold;   // wait for all tokens to drain before sending
  } src_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  char_code = 8'h00;
  logic        end_flag = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [4:0]  token_kind;
  logic [15:0] line_number;
  logic [15:0] column;
  logic [7:0]  indent_tabs;
  logic [15:0] token_length;
  logic [23:0] start_offset;
  logic        last_flag;

  markup_token_scanner u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .char_code(char_code), .end_flag(end_flag),
    .empty(empty), .pop(pop),
    .token_kind(token_kind), .line_number(line_number), .column(column),
    .indent_tabs(indent_tabs), .token_length(token_length),
    .start_offset(start_offset), .last_flag(last_flag)
  );

  always #5 clk = ~clk;

  src_byte_t        source_q[$];
  mts_pkg::token_t  token_exp[$];
  int               mismatches = 0;
  int               send_gap = 0;
  int               pop_gap = 0;

  // Scanner model state
  mts_pkg::mode_t s_mode = mts_pkg::M_LINESTART;
  logic [7:0]  s_chars[WORD_MAX];
  logic [15:0] s_wlen = 0;
  logic [15:0] s_line = 1;
  logic [15:0] s_col = 0;
  logic [7:0]  s_tabs = 0;
  logic [23:0] s_pos = 0;
  logic [23:0] s_begin = 0;

  function automatic logic [15:0] sat16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit is_alnum(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit word_is(string kw);
    if (s_wlen != kw.len() || kw.len() > WORD_MAX) return 0;
    for (int i = 0; i < kw.len(); i++)
      if (s_chars[i] != kw[i]) return 0;
    return 1;
  endfunction

  function automatic mts_pkg::kind_t classify_word();
    if (s_wlen == 1 && s_chars[0] == "p") return mts_pkg::K_PARAGRAPH;
    case (s_chars[0])
      "b": if (word_is("body")) return mts_pkg::K_BODY;
      "c": begin
        if (word_is("con") || word_is("container")) return mts_pkg::K_CONTAINER;
        if (word_is("content")) return mts_pkg::K_BODY;
        if (word_is("css")) return mts_pkg::K_CSS;
      end
      "d": begin
        if (word_is("document")) return mts_pkg::K_DOCUMENT;
        if (word_is("div")) return mts_pkg::K_CONTAINER;
        if (word_is("data")) return mts_pkg::K_HEAD;
      end
      "h": begin
        if (s_wlen >= 2 && s_chars[1] >= "1" && s_chars[1] <= "6")
          return mts_pkg::kind_t'(5'(mts_pkg::K_HEADING1 + (s_chars[1] - "1")));
        if (word_is("head")) return mts_pkg::K_HEAD;
      end
      "t": if (word_is("title")) return mts_pkg::K_TITLE;
      default: ;
    endcase
    return mts_pkg::K_IDENTIFIER;
  endfunction

  function automatic void add_token(mts_pkg::kind_t k, logic [15:0] len, logic [23:0] beg);
    mts_pkg::token_t t;
    t.kind  = k;
    t.line  = s_line;
    t.col   = (s_col >= len) ? s_col - len : 16'd0;
    t.tabs  = s_tabs;
    t.len   = len;
    t.start = beg;
    t.last  = 1'b0;
    token_exp.push_back(t);
  endfunction

  function automatic void clear_scanner();
    s_mode = mts_pkg::M_LINESTART;
    s_wlen = 0;
    s_line = 1;
    s_col = 0;
    s_tabs = 0;
    s_pos = 0;
    s_begin = 0;
  endfunction

  // Byte seen outside any token: whitespace, newline or a token start.
  function automatic void scan_free(logic [7:0] c, logic [23:0] p);
    s_mode = mts_pkg::M_IDLE;
    if (c == mts_pkg::CH_SPACE || c == mts_pkg::CH_CR || c == mts_pkg::CH_TAB) begin
      s_col = sat16(s_col);
    end else if (c == mts_pkg::CH_NL) begin
      s_line = sat16(s_line);
      s_col = 0;
      s_tabs = 0;
      s_mode = mts_pkg::M_LINESTART;
    end else begin
      s_begin = p;
      s_col = sat16(s_col);
      if (c == mts_pkg::CH_QUOTE || c == mts_pkg::CH_BTICK) begin
        s_wlen = 1;
        s_mode = (c == mts_pkg::CH_QUOTE) ? mts_pkg::M_TEXT : mts_pkg::M_RAW;
      end else if (c == mts_pkg::CH_SLASH) begin
        s_mode = mts_pkg::M_SLASH;
      end else if (is_alnum(c)) begin
        s_chars[0] = c;
        s_wlen = 1;
        s_mode = mts_pkg::M_WORD;
      end else if (c == mts_pkg::CH_LPAREN) add_token(mts_pkg::K_LPAREN, 1, p);
      else if (c == mts_pkg::CH_RPAREN) add_token(mts_pkg::K_RPAREN, 1, p);
      else if (c == mts_pkg::CH_BANG) add_token(mts_pkg::K_BANG, 1, p);
      else add_token(mts_pkg::K_ERROR, 1, p);
    end
  endfunction

  // Advance the model by one accepted byte and queue the tokens it causes.
  function automatic void predict_tokens(logic [7:0] c, logic e);
    int before_n = token_exp.size();
    if (e) begin
      case (s_mode)
        mts_pkg::M_WORD:  add_token(classify_word(), s_wlen, s_begin);
        mts_pkg::M_SLASH: add_token(mts_pkg::K_ERROR, 1, s_begin);
        mts_pkg::M_TEXT, mts_pkg::M_RAW: add_token(mts_pkg::K_ERROR, s_wlen, s_begin);
        default: ;
      endcase
      add_token(mts_pkg::K_EOF, 0, s_pos);
      token_exp[token_exp.size() - 1].last = 1'b1;
      clear_scanner();
      return;
    end
    case (s_mode)
      mts_pkg::M_LINESTART: begin
        if (c == mts_pkg::CH_CR || c == mts_pkg::CH_TAB) begin
          if (s_tabs != 8'hFF) s_tabs++;
          s_col = sat16(s_col);
        end else scan_free(c, s_pos);
      end
      mts_pkg::M_WORD: begin
        if (is_alnum(c)) begin
          if (s_wlen < WORD_MAX) s_chars[s_wlen] = c;
          s_wlen = sat16(s_wlen);
          s_col = sat16(s_col);
        end else begin
          add_token(classify_word(), s_wlen, s_begin);
          scan_free(c, s_pos);
        end
      end
      mts_pkg::M_SLASH: begin
        if (c == mts_pkg::CH_SLASH) begin
          s_mode = mts_pkg::M_COMMENT;
          s_col = sat16(s_col);
        end else begin
          add_token(mts_pkg::K_ERROR, 1, s_begin);
          scan_free(c, s_pos);
        end
      end
      mts_pkg::M_COMMENT: begin
        if (c == mts_pkg::CH_NL) scan_free(c, s_pos);
        else s_col = sat16(s_col);
      end
      mts_pkg::M_TEXT, mts_pkg::M_RAW: begin
        if (c == ((s_mode == mts_pkg::M_TEXT) ? mts_pkg::CH_QUOTE : mts_pkg::CH_BTICK)) begin
          add_token((s_mode == mts_pkg::M_TEXT) ? mts_pkg::K_TEXT : mts_pkg::K_RAW,
                    s_wlen, s_begin);
          s_col = sat16(s_col);
          s_mode = mts_pkg::M_IDLE;
        end else if (c == mts_pkg::CH_NL) begin
          s_line = sat16(s_line);
          s_col = 1;
          s_wlen = sat16(s_wlen);
        end else begin
          s_col = sat16(s_col);
          s_wlen = sat16(s_wlen);
        end
      end
      default: scan_free(c, s_pos);
    endcase
    if (s_pos < POS_MAX) s_pos++;
    if (token_exp.size() > before_n) token_exp[token_exp.size() - 1].last = 1'b1;
  endfunction

  // Stimulus helpers
  function automatic void send_byte(logic [7:0] c, bit hold = 0);
    src_byte_t b;
    b.c = c;
    b.e = 1'b0;
    b.hold = hold;
    source_q.push_back(b);
  endfunction

  function automatic void send_end();
    src_byte_t b;
    b.c = 8'($urandom_range(0, 255));
    b.e = 1'b1;
    b.hold = 1'b0;
    source_q.push_back(b);
  endfunction

  function automatic void send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endfunction

  function automatic logic [7:0] rand_alnum();
    int r = $urandom_range(0, 61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + (r - 10));
    return 8'("a" + (r - 36));
  endfunction

  function automatic logic [7:0] rand_printable();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 126));
    while (c == mts_pkg::CH_QUOTE || c == mts_pkg::CH_BTICK);
    return c;
  endfunction

  // One well-formed piece of source with random content, or some noise.
  function automatic void send_random_piece();
    string kws[] = '{"body", "container", "con", "div", "content", "css", "document",
                     "data", "head", "title", "p", "h", "hx", "heads", "cs"};
    int n;
    case ($urandom_range(0, 19))
      0, 1, 2: send_text(kws[$urandom_range(0, kws.size() - 1)]);
      3: begin
        send_byte("h");
        send_byte(8'("0" + $urandom_range(0, 7)));
        n = $urandom_range(0, 3);
        repeat (n) send_byte(rand_alnum());
      end
      4, 5: begin
        n = $urandom_range(1, 12);
        repeat (n) send_byte(rand_alnum());
      end
      6, 7: begin
        n = $urandom_range(1, 3);
        repeat (n) send_byte($urandom_range(0, 1) ? mts_pkg::CH_SPACE : mts_pkg::CH_TAB);
      end
      8, 9: begin
        send_byte(mts_pkg::CH_NL);
        n = $urandom_range(0, 4);
        repeat (n) send_byte($urandom_range(0, 3) ? mts_pkg::CH_TAB : mts_pkg::CH_CR);
      end
      10, 11: begin
        logic [7:0] q = $urandom_range(0, 1) ? mts_pkg::CH_QUOTE : mts_pkg::CH_BTICK;
        send_byte(q);
        n = $urandom_range(0, 10);
        repeat (n) send_byte($urandom_range(0, 7) ? rand_printable() : mts_pkg::CH_NL);
        if ($urandom_range(0, 9)) send_byte(q);
      end
      12: begin
        send_text("//");
        n = $urandom_range(0, 8);
        repeat (n) send_byte(rand_printable());
        send_byte(mts_pkg::CH_NL);
      end
      13, 14: send_byte($urandom_range(0, 2) == 0 ? mts_pkg::CH_LPAREN
                        : ($urandom_range(0, 1) ? mts_pkg::CH_RPAREN : mts_pkg::CH_BANG));
      15: begin
        send_byte(mts_pkg::CH_SLASH);
        if ($urandom_range(0, 1)) send_byte(rand_printable());
      end
      16, 17: send_byte(8'($urandom_range(0, 255)));
      18: send_byte(rand_printable());
      default: if ($urandom_range(0, 1)) send_end();
    endcase
  endfunction

  initial begin
    // Directed: a mix of kinds, heading prefixes, lone slash, unknown and high bytes.
    send_text("h3x (body)!\n\t");
    send_byte(mts_pkg::CH_CR);
    send_text("\tp \"a\nb\" ");
    send_byte(mts_pkg::CH_BTICK);
    send_text("r");
    send_byte(mts_pkg::CH_BTICK);
    send_text(" // c\n/a @");
    send_byte(8'hFF);
    send_byte(8'h00);
    send_end();
    send_text("\"ab");
    send_end();
    send_text("w");
    send_end();
    send_text("/");
    send_end();
    // Drain point: hold the next byte until all tokens are out.
    send_byte("x", 1);
    send_end();

    // Saturation of the tab count.
    repeat (300) send_byte(mts_pkg::CH_TAB);
    send_byte("t");
    send_byte(mts_pkg::CH_SPACE);
    send_end();

    send_byte("y", 1);
    while (source_q.size() < ITEMS) send_random_piece();
    send_end();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: hold the byte while full, insert random gaps, none near the end.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      send_gap = 0;
    end else begin
      if (push && !full) begin
        predict_tokens(char_code, end_flag);
        void'(source_q.pop_front());
      end
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (source_q.size() == 0 || (source_q[0].hold && token_exp.size() != 0)) begin
        push <= 1'b0;
      end else if (source_q.size() > 200 && $urandom_range(0, 19) == 0) begin
        send_gap = $urandom_range(0, 10);
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        char_code <= source_q[0].c;
        end_flag <= source_q[0].e;
      end
    end
  end

  // Monitor: take token words, compare against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_gap = 0;
    end else begin
      if (pop && !empty) begin
        if (token_exp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected token word kind=%0d len=%0d start=%0d", $realtime,
                     token_kind, token_length, start_offset);
        end else begin
          mts_pkg::token_t want;
          want = token_exp.pop_front();
          if (token_kind !== want.kind || line_number !== want.line ||
              column !== want.col || indent_tabs !== want.tabs ||
              token_length !== want.len || start_offset !== want.start ||
              last_flag !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: token mismatch exp kind=%0d line=%0d col=%0d tabs=%0d ",
                        "len=%0d start=%0d last=%0b got kind=%0d line=%0d col=%0d ",
                        "tabs=%0d len=%0d start=%0d last=%0b"}, $realtime,
                       want.kind, want.line, want.col, want.tabs, want.len, want.start,
                       want.last, token_kind, line_number, column, indent_tabs,
                       token_length, start_offset, last_flag);
          end
        end
      end
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else if (source_q.size() > 200 && $urandom_range(0, 15) == 0) begin
        pop_gap = $urandom_range(0, 10);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    wait (!rst);
    while (source_q.size() != 0 || token_exp.size() != 0 || push) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #50ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
